// ----- src/ranked_sorted_list_assert.svh -----
// ----------------------------------------------------------------------------
// ranked sorted list assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef RANKED_SORTED_LIST_ASSERT_SVH
`define RANKED_SORTED_LIST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ranked sorted list: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define RSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ranked sorted list: next-cycle check failed");

`endif

// ----- src/rsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rsl_pkg
// shared types and codes of the ranked sorted list
// ----------------------------------------------------------------------------
`default_nettype none

package rsl_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_DELETED  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_REPORT
    } t_state;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- src/rsl_cell.sv -----
// ----------------------------------------------------------------------------
// rsl_cell
// one slot of the sorted chain: holds a key, compares, shifts with neighbours
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 31,
    parameter int POS_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rsl_pkg::t_cell_ctrl   i_ctrl,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [POS_BITS-1:0]   i_position,
    input  wire logic [KEY_BITS-1:0]   i_prev_key,
    input  wire logic                  i_prev_valid,
    input  wire logic                  i_prev_ge,
    input  wire logic [KEY_BITS-1:0]   i_next_key,
    input  wire logic                  i_next_valid,
    output logic [KEY_BITS-1:0]        o_key,
    output logic                       o_valid,
    output logic                       o_ge,
    output logic                       o_bound
);

    localparam logic [POS_BITS-1:0] IDX = POS_BITS'(INDEX);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_valid;
    logic                n_valid;
    logic                r_bound;
    logic                n_bound;
    logic                w_ge;

    // stored key ranks at or ahead of the broadcast key
    assign w_ge = r_valid && (r_key >= i_key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        n_bound = r_bound;
        if (i_ctrl.ins_en) begin
            n_bound = i_prev_ge && !w_ge;
            if (!w_ge) begin
                if (i_prev_ge) begin
                    n_key   = i_key;
                    n_valid = 1'b1;
                end else begin
                    n_key   = i_prev_key;
                    n_valid = i_prev_valid;
                end
            end
        end else if (i_ctrl.del_en && (IDX >= i_position)) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_bound <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_bound <= n_bound;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_ge    = w_ge;
    assign o_bound = r_bound;

endmodule

`default_nettype wire

// ----- src/rsl_rank_enc.sv -----
// ----------------------------------------------------------------------------
// rsl_rank_enc
// turns the one-hot landing flags of the chain into a binary rank
// ----------------------------------------------------------------------------
`default_nettype none

module rsl_rank_enc #(
    parameter int CAPACITY = 1024,
    parameter int POS_BITS = 10
) (
    input  wire logic [CAPACITY-1:0] i_onehot,
    output logic [POS_BITS-1:0]      o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_onehot[i]) begin
                o_index = o_index | POS_BITS'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/ranked_sorted_list.sv -----
// ----------------------------------------------------------------------------
// ranked_sorted_list
// bounded multiset of keys kept in descending order in a chain of cells
// ----------------------------------------------------------------------------
// Each command transfer (start high while busy is low) produces exactly one
// result, shown on o_rank/o_status for a single cycle with o_strobe high.
// The receiver cannot stall, so results must be taken as they appear. In
// the accept cycle the key (or delete position) is broadcast to every cell,
// which compares and shifts against its neighbours at that edge; in the
// following cycle busy is high while the one-hot landing flags of the chain
// are encoded into the rank. The result strobes in the cycle after that,
// and a new command may be transferred in that same cycle; no new command
// is taken while busy is high. Inserts place the key after every
// stored key that is greater or equal, so equal keys keep arrival order.
// An insert into a full store and a delete beyond the stored count change
// nothing and are flagged in the status; rank is zero for every result but
// that of a stored insert.
// No clearing pass is needed after reset: of the cells' registers only valid and bound reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ranked_sorted_list #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 31,
    localparam int POS_BITS = $clog2(CAPACITY)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_cmd,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [POS_BITS-1:0] i_position,
    output logic                     o_strobe,
    output logic [POS_BITS-1:0]      o_rank,
    output logic [1:0]               o_status
);

    `include "ranked_sorted_list_assert.svh"

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

    // sequencer state and bookkeeping
    rsl_pkg::t_state     r_state;
    rsl_pkg::t_state     n_state;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [1:0]          r_status;
    logic [1:0]          n_status;

    // result registers
    logic                r_strobe;
    logic                n_strobe;
    logic [POS_BITS-1:0] r_rank;
    logic [POS_BITS-1:0] n_rank;
    logic [1:0]          r_out_status;
    logic [1:0]          n_out_status;

    logic                w_accept;
    logic                w_full;
    logic                w_range;
    logic                w_drop;
    logic                w_report;
    rsl_pkg::t_cell_ctrl w_ctrl;
    logic [POS_BITS-1:0] w_enc_rank;

    // chain wiring
    logic [KEY_BITS-1:0] w_key   [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_bound;

    assign busy     = (r_state == rsl_pkg::S_REPORT);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CAP_CNT);
    assign w_range  = (CNT_BITS'(i_position) >= r_count);
    // insert refused because the store is full
    assign w_drop   = w_accept && (i_cmd == rsl_pkg::CMD_INSERT) && w_full;

    // broadcast enables, only for commands that really change the store
    always_comb begin
        w_ctrl.ins_en = w_accept && (i_cmd == rsl_pkg::CMD_INSERT) && !w_full;
        w_ctrl.del_en = w_accept && (i_cmd == rsl_pkg::CMD_DELETE) && !w_range;
    end

    // status and count, decided at the transfer
    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        if (w_accept) begin
            if (i_cmd == rsl_pkg::CMD_INSERT) begin
                n_status = w_full ? rsl_pkg::STAT_FULL : rsl_pkg::STAT_INSERTED;
            end else begin
                n_status = w_range ? rsl_pkg::STAT_RANGE : rsl_pkg::STAT_DELETED;
            end
        end
        if (w_ctrl.ins_en) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_ctrl.del_en) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    // next state
    always_comb begin
        case (r_state)
            rsl_pkg::S_IDLE:   n_state = w_accept ? rsl_pkg::S_REPORT : rsl_pkg::S_IDLE;
            rsl_pkg::S_REPORT: n_state = rsl_pkg::S_IDLE;
            default:           n_state = rsl_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            rsl_pkg::S_REPORT: w_report = 1'b1;
            default:           w_report = 1'b0;
        endcase
    end

    // result register next values
    always_comb begin
        n_strobe     = w_report;
        n_rank       = r_rank;
        n_out_status = r_out_status;
        if (w_report) begin
            n_out_status = r_status;
            n_rank       = (r_status == rsl_pkg::STAT_INSERTED) ? w_enc_rank : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsl_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_rank       <= n_rank;
        r_out_status <= n_out_status;
    end

    assign o_strobe = r_strobe;
    assign o_rank   = r_rank;
    assign o_status = r_out_status;

    // chain of cells, head holds the largest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_prev_key;
        logic                w_prev_valid;
        logic                w_prev_ge;
        logic [KEY_BITS-1:0] w_next_key;
        logic                w_next_valid;

        if (g == 0) begin : g_head
            // head: nothing ahead, so the key lands here once it outranks this slot
            assign w_prev_key   = '0;
            assign w_prev_valid = 1'b0;
            assign w_prev_ge    = 1'b1;
        end else begin : g_body
            assign w_prev_key   = w_key[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_ge    = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            // tail: an empty slot shifts in on delete
            assign w_next_key   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_key   = w_key[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        rsl_cell #(
            .INDEX    (g),
            .KEY_BITS (KEY_BITS),
            .POS_BITS (POS_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (i_key),
            .i_position   (i_position),
            .i_prev_key   (w_prev_key),
            .i_prev_valid (w_prev_valid),
            .i_prev_ge    (w_prev_ge),
            .i_next_key   (w_next_key),
            .i_next_valid (w_next_valid),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_ge         (w_ge[g]),
            .o_bound      (w_bound[g])
        );
    end

    // landing flag of the last insert to binary rank, in the report state of an item
    rsl_rank_enc #(
        .CAPACITY (CAPACITY),
        .POS_BITS (POS_BITS)
    ) u_rank_enc (
        .i_onehot (w_bound),
        .o_index  (w_enc_rank)
    );

    // a report cycle is always followed by exactly one result strobe
    `RSL_ASSERT_NEXT(a_report_strobe, i_clk, i_rst_n, busy, o_strobe)
    // a result never coincides with the block being busy
    `RSL_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    // the count never passes capacity
    `RSL_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    // a refused insert leaves the store untouched
    `RSL_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, w_drop, r_count == $past(r_count))
    // an inserted key lands in exactly one cell
    `RSL_ASSERT_NEXT(a_one_landing, i_clk, i_rst_n, w_ctrl.ins_en, $onehot(w_bound))
    // a stored insert always finds a free slot at the tail
    `RSL_ASSERT_SAME(a_tail_free, i_clk, i_rst_n, w_ctrl.ins_en, !w_ge[CAPACITY-1])

endmodule

`default_nettype wire

// ----- dv/ranked_sorted_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ranked_sorted_list_tb
// self-checking bench for the ranked sorted list: every command transfer is
// run through a queue-based copy of the descending store, and each strobed
// result is compared field by field with the oldest expected result
// ----------------------------------------------------------------------------
`default_nettype none

module ranked_sorted_list_tb;

    localparam int LIST_DEPTH = 1024;
    localparam int GROW_DEPTH = 80;
    localparam int KEY_W      = 31;
    localparam int POS_W      = 10;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] rank;
        logic [1:0]       status;
    } t_list_result;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             i_cmd      = rsl_pkg::CMD_INSERT;
    logic [KEY_W-1:0] i_key      = '0;
    logic [POS_W-1:0] i_position = '0;
    logic             busy;
    logic             o_strobe;
    logic [POS_W-1:0] o_rank;
    logic [1:0]       o_status;

    // bench copy of the store, highest key first
    logic [KEY_W-1:0] model_keys[$];
    t_list_result     pending_results[$];
    int               mismatch_count  = 0;
    int               sender_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    ranked_sorted_list #(
        .CAPACITY (LIST_DEPTH),
        .KEY_BITS (KEY_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_position (i_position),
        .o_strobe   (o_strobe),
        .o_rank     (o_rank),
        .o_status   (o_status)
    );

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // updates the bench store and returns the status the block must give
    function automatic t_list_result apply_command(input logic cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [POS_W-1:0] pos);
        t_list_result res;
        int slot;
        res  = '0;
        slot = 0;
        if (cmd == rsl_pkg::CMD_INSERT) begin
            if (model_keys.size() >= LIST_DEPTH) begin
                res.status = rsl_pkg::STAT_FULL;
            end else begin
                // land after every stored key that is greater or equal
                while (slot < model_keys.size() && model_keys[slot] >= key)
                    slot++;
                model_keys.insert(slot, key);
                res.rank   = POS_W'(slot);
                res.status = rsl_pkg::STAT_INSERTED;
            end
        end else if (int'(pos) >= model_keys.size()) begin
            res.status = rsl_pkg::STAT_RANGE;
        end else begin
            model_keys.delete(int'(pos));
            res.status = rsl_pkg::STAT_DELETED;
        end
        return res;
    endfunction

    // one command transfer; start is left high so back-to-back items flow
    task automatic send_command(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_key      <= key;
        i_position <= pos;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        pending_results.push_back(apply_command(cmd, key, pos));
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(4))
            0: begin
                return KEY_W'($urandom_range(15));
            end
            1: begin
                return $urandom_range(1) ? KEY_MAX - KEY_W'($urandom_range(1))
                                         : KEY_W'($urandom_range(1));
            end
            2: begin
                // exact copy of a stored key, so equal keys meet often
                if (model_keys.size() > 0)
                    return model_keys[$urandom_range(model_keys.size() - 1)];
                return KEY_W'($urandom);
            end
            default: begin
                return KEY_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int count;
        count = model_keys.size();
        case ($urandom_range(9))
            0: begin
                return POS_W'($urandom);
            end
            1: begin
                return POS_W'(count);
            end
            default: begin
                if (count > 0)
                    return POS_W'($urandom_range(count - 1));
                return POS_W'($urandom);
            end
        endcase
    endfunction

    // empty-store deletes, extreme keys, equal keys, both ends of the order
    task automatic test_directed();
        send_command(rsl_pkg::CMD_DELETE, KEY_MAX, '0);
        send_command(rsl_pkg::CMD_DELETE, '0, '1);
        send_command(rsl_pkg::CMD_INSERT, '0, '1);
        send_command(rsl_pkg::CMD_INSERT, KEY_MAX, '0);
        send_command(rsl_pkg::CMD_INSERT, KEY_MAX, '1);
        send_command(rsl_pkg::CMD_INSERT, '0, '0);
        send_command(rsl_pkg::CMD_INSERT, 31'h2AAA_AAAA, 10'h155);
        send_command(rsl_pkg::CMD_INSERT, 31'h5555_5555, 10'h2AA);
        send_command(rsl_pkg::CMD_INSERT, 31'h0000_0001, '1);
        send_command(rsl_pkg::CMD_DELETE, KEY_MAX, POS_W'(model_keys.size()));
        send_command(rsl_pkg::CMD_DELETE, 31'h5555_5555, POS_W'(model_keys.size() - 1));
        send_command(rsl_pkg::CMD_DELETE, '0, '0);
        send_command(rsl_pkg::CMD_DELETE, KEY_MAX, '1);
        send_command(rsl_pkg::CMD_INSERT, 31'h2AAA_AAAA, '0);
        send_command(rsl_pkg::CMD_DELETE, 31'h2AAA_AAAA, 10'd1);
    endtask

    task automatic test_random_mix(input int n_items, input int insert_pct);
        repeat (n_items) begin
            if ($urandom_range(99) < insert_pct)
                send_command(rsl_pkg::CMD_INSERT, pick_key(), POS_W'($urandom));
            else
                send_command(rsl_pkg::CMD_DELETE, KEY_W'($urandom), pick_position());
        end
    endtask

    // grow to a deep store, land keys at both ends of the order, delete the
    // last entry and one past the end, then drain back to empty
    task automatic test_grow_and_drain();
        while (model_keys.size() < GROW_DEPTH) begin
            if ($urandom_range(99) < 90)
                send_command(rsl_pkg::CMD_INSERT, pick_key(), POS_W'($urandom));
            else
                send_command(rsl_pkg::CMD_DELETE, KEY_W'($urandom), pick_position());
        end
        send_command(rsl_pkg::CMD_INSERT, '0, '0);
        send_command(rsl_pkg::CMD_INSERT, KEY_MAX, '1);
        send_command(rsl_pkg::CMD_DELETE, '0, POS_W'(model_keys.size() - 1));
        send_command(rsl_pkg::CMD_DELETE, KEY_MAX, POS_W'(model_keys.size()));
        while (model_keys.size() > 0) begin
            if ($urandom_range(99) < 90)
                send_command(rsl_pkg::CMD_DELETE, KEY_W'($urandom), pick_position());
            else
                send_command(rsl_pkg::CMD_INSERT, pick_key(), POS_W'($urandom));
        end
    endtask

    // result checker: the receiver cannot stall, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result rank %0d status %0d",
                                          o_rank, o_status));
            end else begin
                exp_res = pending_results.pop_front();
                if (o_rank !== exp_res.rank)
                    report_mismatch($sformatf("rank %0d, expected %0d",
                                              o_rank, exp_res.rank));
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, exp_res.status));
            end
        end
    end

    initial begin
        int wait_cycles;
        wait_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 28;
        test_directed();
        test_random_mix(150, 60);
        sender_idle_pct = 70;
        test_grow_and_drain();
        sender_idle_pct = 0;
        test_random_mix(110, 55);
        start <= 1'b0;

        while (pending_results.size() > 0 && wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));

        if (mismatch_count == 0)
            $display("ranked_sorted_list regression: pass");
        else
            $display("ranked_sorted_list regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("ranked_sorted_list regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
